[hdl/ssp_pkg.sv]
// shared types, constants, font table and helper functions for the status screen generator
package ssp_pkg;

  // panel geometry (portrait); the canvas is rotated to landscape
  localparam int PANEL_WIDTH  = 480;
  localparam int PANEL_HEIGHT = 640;

  // headline store
  localparam int HEADLINE_MAX_CHARS = 15;
  localparam int HL_SLOTS           = 16;
  localparam int HL_LEN_W           = 5;

  typedef logic [HL_SLOTS-1:0][7:0] hl_text_t;

  // config register indexes (byte address / 8)
  localparam logic [1:0] CFG_VOICE   = 2'd0;
  localparam logic [1:0] CFG_HL_LOW  = 2'd1;
  localparam logic [1:0] CFG_HL_HIGH = 2'd2;

  localparam logic [63:0] HL_LOW_RESET  = 64'h0000_0059_4441_4552;
  localparam logic [55:0] HL_HIGH_RESET = 56'h0;

  localparam hl_text_t VOICE_TEXT = {88'd0, 8'h45, 8'h43, 8'h49, 8'h4F, 8'h56};
  localparam hl_text_t READY_TEXT = {88'd0, 8'h59, 8'h44, 8'h41, 8'h45, 8'h52};
  localparam logic [HL_LEN_W-1:0] FIXED_HL_LEN = 5'd5;
  localparam logic [HL_LEN_W-1:0] FULL_HL_LEN  = 5'd16;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_en_t;

  function automatic logic [15:0] pack565(int r, int g, int b);
    return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hFF) >> 3));
  endfunction

  localparam logic [15:0] COL_BG      = pack565(8, 12, 22);
  localparam logic [15:0] COL_BAR     = pack565(18, 29, 48);
  localparam logic [15:0] COL_CYAN    = pack565(93, 224, 255);
  localparam logic [15:0] COL_MINT    = pack565(108, 239, 174);
  localparam logic [15:0] COL_ORANGE  = pack565(255, 177, 75);
  localparam logic [15:0] COL_WHITE   = pack565(240, 248, 255);
  localparam logic [15:0] COL_FACE_V  = pack565(56, 92, 125);
  localparam logic [15:0] COL_FACE    = pack565(45, 69, 103);

  // face geometry
  localparam int FACE_CX = 320;
  localparam int FACE_CY = 245;
  localparam int FACE_R  = 78;
  localparam int FACE_R2 = FACE_R * FACE_R;

  // text lanes, in priority order
  localparam int NUM_LANES  = 4;
  localparam int LANE_TITLE = 0;
  localparam int LANE_HEAD  = 1;
  localparam int LANE_MIC   = 2;
  localparam int LANE_AGENT = 3;

  localparam int TXT_X0    [NUM_LANES] = '{28, 260, 28, 475};
  localparam int TXT_Y0    [NUM_LANES] = '{22, 350, 405, 405};
  localparam int TXT_SCALE [NUM_LANES] = '{4, 5, 3, 3};
  localparam int TXT_LEN   [NUM_LANES] = '{6, 16, 9, 5};

  localparam int FONT_COLS  = 5;
  localparam int FONT_ROWS  = 7;
  localparam int CELL_COLS  = 6;

  // reciprocal division: q = (v * ceil(2^S / d)) >> S, exact for v < 1024, d <= 30
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
  localparam int RECIP_W     = 19;

  localparam logic [7:0] FONT_ROM [26][5] = '{
    '{8'h1E, 8'h05, 8'h05, 8'h05, 8'h1E}, '{8'h1F, 8'h15, 8'h15, 8'h15, 8'h0A},
    '{8'h0E, 8'h11, 8'h11, 8'h11, 8'h0A}, '{8'h1F, 8'h11, 8'h11, 8'h0A, 8'h04},
    '{8'h1F, 8'h15, 8'h15, 8'h11, 8'h11}, '{8'h1F, 8'h05, 8'h05, 8'h01, 8'h01},
    '{8'h0E, 8'h11, 8'h15, 8'h15, 8'h1D}, '{8'h1F, 8'h04, 8'h04, 8'h04, 8'h1F},
    '{8'h00, 8'h11, 8'h1F, 8'h11, 8'h00}, '{8'h08, 8'h10, 8'h10, 8'h0F, 8'h00},
    '{8'h1F, 8'h04, 8'h0A, 8'h11, 8'h00}, '{8'h1F, 8'h10, 8'h10, 8'h10, 8'h10},
    '{8'h1F, 8'h02, 8'h04, 8'h02, 8'h1F}, '{8'h1F, 8'h02, 8'h04, 8'h08, 8'h1F},
    '{8'h0E, 8'h11, 8'h11, 8'h11, 8'h0E}, '{8'h1F, 8'h05, 8'h05, 8'h05, 8'h02},
    '{8'h0E, 8'h11, 8'h19, 8'h11, 8'h1E}, '{8'h1F, 8'h05, 8'h0D, 8'h15, 8'h12},
    '{8'h12, 8'h15, 8'h15, 8'h15, 8'h09}, '{8'h01, 8'h01, 8'h1F, 8'h01, 8'h01},
    '{8'h0F, 8'h10, 8'h10, 8'h10, 8'h0F}, '{8'h07, 8'h08, 8'h10, 8'h08, 8'h07},
    '{8'h1F, 8'h08, 8'h04, 8'h08, 8'h1F}, '{8'h11, 8'h0A, 8'h04, 8'h0A, 8'h11},
    '{8'h01, 8'h02, 8'h1C, 8'h02, 8'h01}, '{8'h19, 8'h15, 8'h13, 8'h11, 8'h00}
  };

  // one glyph column, bit n = font row n; blank outside the table
  function automatic logic [FONT_ROWS-1:0] font_column(logic [4:0] letter, logic [2:0] col);
    logic [FONT_ROWS-1:0] bits;
    bits = '0;
    if (letter < 5'd26 && col < 3'(FONT_COLS)) begin
      bits = FONT_ROM[letter][col][FONT_ROWS-1:0];
    end
    return bits;
  endfunction

  // characters of the fixed strings
  function automatic logic [7:0] fixed_char(logic [1:0] lane, logic [3:0] cell_no);
    logic [7:0] ch;
    ch = 8'h00;
    case (lane)
      2'(LANE_TITLE): begin
        case (cell_no)
          4'd0:    ch = 8'h48;
          4'd1:    ch = 8'h41;
          4'd2:    ch = 8'h4B;
          4'd3:    ch = 8'h49;
          4'd4:    ch = 8'h4D;
          4'd5:    ch = 8'h49;
          default: ch = 8'h00;
        endcase
      end
      2'(LANE_MIC): begin
        case (cell_no)
          4'd0:    ch = 8'h4D;
          4'd1:    ch = 8'h49;
          4'd2:    ch = 8'h43;
          4'd3:    ch = 8'h20;
          4'd4:    ch = 8'h52;
          4'd5:    ch = 8'h45;
          4'd6:    ch = 8'h41;
          4'd7:    ch = 8'h44;
          4'd8:    ch = 8'h59;
          default: ch = 8'h00;
        endcase
      end
      2'(LANE_AGENT): begin
        case (cell_no)
          4'd0:    ch = 8'h41;
          4'd1:    ch = 8'h47;
          4'd2:    ch = 8'h45;
          4'd3:    ch = 8'h4E;
          4'd4:    ch = 8'h54;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic in_box(int x, int y, int x0, int y0, int w, int h);
    return (x >= x0) && (x < x0 + w) && (y >= y0) && (y < y0 + h);
  endfunction

endpackage

[hdl/ssp_cfg.sv]
// configuration registers and registered headline text selection
module ssp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  output logic                          voice,
  output ssp_pkg::hl_text_t             hl_text,
  output logic [ssp_pkg::HL_LEN_W-1:0]  hl_len
);
  import ssp_pkg::*;

  logic                voice_r;
  logic [63:0]         hl_low_r;
  logic [55:0]         hl_high_r;
  hl_text_t            hl_text_r, hl_text_nxt;
  logic [HL_LEN_W-1:0] hl_len_r, hl_len_nxt;

  logic                wr_en;
  logic [1:0]          reg_idx;
  logic [HL_SLOTS-1:0] zero_byte;
  logic [HL_SLOTS-1:0] ended;
  logic [HL_SLOTS-1:0] pre_mask;
  hl_text_t            raw_text;
  hl_text_t            head_text;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_r   <= 1'b0;
      hl_low_r  <= HL_LOW_RESET;
      hl_high_r <= HL_HIGH_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        CFG_VOICE:   voice_r   <= pwdata[0];
        CFG_HL_LOW:  hl_low_r  <= pwdata;
        CFG_HL_HIGH: hl_high_r <= pwdata[55:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      CFG_VOICE:   prdata = {63'd0, voice_r};
      CFG_HL_LOW:  prdata = hl_low_r;
      CFG_HL_HIGH: prdata = {8'd0, hl_high_r};
      default:     prdata = '0;
    endcase
  end

  // first zero byte (or the slot limit) ends the headline
  always_comb begin
    raw_text = {8'd0, hl_high_r, hl_low_r};
    for (int i = 0; i < HL_SLOTS; i++) begin
      zero_byte[i] = (raw_text[i] == 8'd0) || (i >= HEADLINE_MAX_CHARS);
    end
    for (int i = 0; i < HL_SLOTS; i++) begin
      pre_mask     = HL_SLOTS'((32'd2 << i) - 32'd1);
      ended[i]     = |(zero_byte & pre_mask);
      head_text[i] = ended[i] ? 8'd0 : raw_text[i];
    end
    if (voice_r) begin
      hl_text_nxt = VOICE_TEXT;
      hl_len_nxt  = FIXED_HL_LEN;
    end else if (head_text[0] != 8'd0) begin
      hl_text_nxt = head_text;
      hl_len_nxt  = FULL_HL_LEN;
    end else begin
      hl_text_nxt = READY_TEXT;
      hl_len_nxt  = FIXED_HL_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_text_r <= READY_TEXT;
      hl_len_r  <= FIXED_HL_LEN;
    end else begin
      hl_text_r <= hl_text_nxt;
      hl_len_r  <= hl_len_nxt;
    end
  end

  assign voice   = voice_r;
  assign hl_text = hl_text_r;
  assign hl_len  = hl_len_r;

endmodule

[hdl/ssp_shape.sv]
// four-stage shape layer pipeline: background, bars, face, eyes, pupils, mouth
module ssp_shape (
  input  logic               clk,
  input  ssp_pkg::stage_en_t en,
  input  logic               voice,
  input  logic [9:0]         x,
  input  logic signed [10:0] y,
  output logic [15:0]        colour
);
  import ssp_pkg::*;

  // stage 1
  logic signed [10:0] dx_r, dx_nxt;
  logic signed [10:0] dy_r, dy_nxt;
  logic [4:0]         flags1_r, flags1_nxt;
  // stage 2
  logic [18:0]        sqx_r, sqx_nxt;
  logic [16:0]        sqy_r, sqy_nxt;
  logic [4:0]         flags2_r;
  // stage 3 and 4
  logic [15:0]        col3_r, col3_nxt;
  logic [15:0]        col4_r;

  logic signed [21:0] sqx_full, sqy_full;
  logic [19:0]        dist2;
  int                 xi, yi;

  // flags: bar, accent, eye, pupil, mouth
  always_comb begin
    xi = int'({1'b0, x});
    yi = int'(y);
    dx_nxt = $signed({1'b0, x}) - 11'sd320;
    dy_nxt = y - 11'sd245;
    flags1_nxt[0] = in_box(xi, yi, 0, 0, PANEL_HEIGHT, 62);
    flags1_nxt[1] = in_box(xi, yi, 0, 62, PANEL_HEIGHT, 3);
    flags1_nxt[2] = in_box(xi, yi, 258, 173, 38, 34) || in_box(xi, yi, 344, 173, 38, 34);
    flags1_nxt[3] = in_box(xi, yi, 289, 228, 14, 16) || in_box(xi, yi, 337, 228, 14, 16);
    flags1_nxt[4] = in_box(xi, yi, 306, 276, 28, 8);
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      flags1_r <= flags1_nxt;
    end
  end

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;
  assign sqx_nxt  = sqx_full[18:0];
  assign sqy_nxt  = sqy_full[16:0];

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
      flags2_r <= flags1_r;
    end
  end

  always_comb begin
    dist2    = 20'(sqx_r) + 20'(sqy_r);
    col3_nxt = COL_BG;
    if (flags2_r[0]) col3_nxt = COL_BAR;
    if (flags2_r[1]) col3_nxt = voice ? COL_ORANGE : COL_CYAN;
    if (dist2 < 20'(FACE_R2)) col3_nxt = voice ? COL_FACE_V : COL_FACE;
    if (flags2_r[2]) col3_nxt = voice ? COL_ORANGE : COL_CYAN;
    if (flags2_r[3]) col3_nxt = COL_WHITE;
    if (flags2_r[4]) col3_nxt = voice ? COL_ORANGE : COL_MINT;
  end

  always_ff @(posedge clk) begin
    if (en.ld3) col3_r <= col3_nxt;
    if (en.ld4) col4_r <= col3_r;
  end

  assign colour = col4_r;

endmodule

[hdl/ssp_text_lane.sv]
// four-stage text lane: cell and row by reciprocal multiply, column from the remainder, glyph lookup
module ssp_text_lane #(
  parameter int LANE = 0
) (
  input  logic                          clk,
  input  ssp_pkg::stage_en_t            en,
  input  logic [9:0]                    x,
  input  logic signed [10:0]            y,
  input  ssp_pkg::hl_text_t             hl_text,
  input  logic [ssp_pkg::HL_LEN_W-1:0]  hl_len,
  output logic                          hit
);
  import ssp_pkg::*;

  localparam int X0    = TXT_X0[LANE];
  localparam int Y0    = TXT_Y0[LANE];
  localparam int SCALE = TXT_SCALE[LANE];
  localparam int LEN   = TXT_LEN[LANE];
  localparam int PITCH = CELL_COLS * SCALE;
  localparam int RP    = (RECIP_ONE + PITCH - 1) / PITCH;
  localparam int RS    = (RECIP_ONE + SCALE - 1) / SCALE;

  // stage 1
  logic [9:0]  u1_r, u1_nxt;
  logic [8:0]  w1_r, w1_nxt;
  logic        ok1_r, ok1_nxt;
  // stage 2
  logic [28:0] pu_r, pu_nxt;
  logic [27:0] pw_r, pw_nxt;
  logic [9:0]  u2_r;
  logic        ok2_r;
  // stage 3
  logic [5:0]  cell3_r;
  logic [7:0]  row3_r;
  logic [9:0]  u3_r;
  logic        ok3_r;
  // stage 4
  logic [7:0]  ch4_r, ch4_nxt;
  logic [2:0]  col4_r, col4_nxt;
  logic [2:0]  row4_r;
  logic        ok4_r, ok4_nxt;

  logic [10:0] cell_base;
  logic [10:0] rem;
  logic        col_ok;
  logic [7:0]  ch_sel;
  logic        len_ok;
  logic        letter;
  logic [FONT_ROWS-1:0] glyph;

  always_comb begin
    u1_nxt  = x - 10'(X0);
    w1_nxt  = 9'(y - 11'(Y0));
    ok1_nxt = (x >= 10'(X0)) && (y >= $signed(11'(Y0)));
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      u1_r  <= u1_nxt;
      w1_r  <= w1_nxt;
      ok1_r <= ok1_nxt;
    end
  end

  assign pu_nxt = 29'(u1_r) * 29'(RP);
  assign pw_nxt = 28'(w1_r) * 28'(RS);

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      pu_r  <= pu_nxt;
      pw_r  <= pw_nxt;
      u2_r  <= u1_r;
      ok2_r <= ok1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      cell3_r <= pu_r[RECIP_SHIFT +: 6];
      row3_r  <= pw_r[RECIP_SHIFT +: 8];
      u3_r    <= u2_r;
      ok3_r   <= ok2_r;
    end
  end

  generate
    if (LANE == LANE_HEAD) begin : g_head
      assign ch_sel = hl_text[cell3_r[3:0]];
      assign len_ok = cell3_r < 6'(hl_len);
    end else begin : g_fixed
      assign ch_sel = fixed_char(2'(LANE), cell3_r[3:0]);
      assign len_ok = cell3_r < 6'(LEN);
    end
  endgenerate

  // remainder within the cell is below the pitch, column is remainder / scale
  always_comb begin
    cell_base = 11'(cell3_r) * 11'(PITCH);
    rem       = 11'(u3_r) - cell_base;
    col_ok    = rem < 11'(FONT_COLS * SCALE);
    col4_nxt  = '0;
    for (int k = 1; k < FONT_COLS; k++) begin
      if (rem >= 11'(k * SCALE)) col4_nxt = col4_nxt + 3'd1;
    end
    ch4_nxt = ch_sel;
    ok4_nxt = ok3_r && len_ok && col_ok && (row3_r < 8'(FONT_ROWS));
  end

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      ch4_r  <= ch4_nxt;
      col4_r <= col4_nxt;
      row4_r <= row3_r[2:0];
      ok4_r  <= ok4_nxt;
    end
  end

  assign letter = (ch4_r >= CHAR_A) && (ch4_r <= CHAR_Z);
  assign glyph  = font_column(5'(ch4_r - CHAR_A), col4_r);
  assign hit    = ok4_r && letter && glyph[row4_r];

endmodule

[hdl/status_screen_pixel_generator.sv]
// status screen pixel generator top level: pipeline control, layers and output register
// an accepted pixel passes stages 1 to 4 and then the output register before it appears on out_valid
// throughput: one pixel per clock while out_stall is low, five register stages (two arithmetic, two lookup, output)
// a stage refills as soon as its word moves on, so bubbles close up under output stall
// reset: synchronous, clears all valid bits and loads voice off and headline READY
// configuration is taken at any time but must only change while the pipeline is empty
module status_screen_pixel_generator (
  input  logic        clk,
  input  logic        rst_n,
  // pixel coordinate channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [8:0]  in_panel_column,
  input  logic [9:0]  in_panel_row,
  // colour channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_colour,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ssp_pkg::*;

  // valid bits for each stage, plus the output register
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic v4_r, v4_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_colour_r, out_colour_nxt;

  stage_en_t en;
  logic      out_ld;

  logic                voice;
  hl_text_t            hl_text;
  logic [HL_LEN_W-1:0] hl_len;

  // canvas coordinate: x is the panel row, y is the mirrored panel column
  logic [9:0]         canvas_x;
  logic signed [10:0] canvas_y;

  logic [15:0]          shape_colour;
  logic [NUM_LANES-1:0] hits;

  // --------------------------------------------------------------------------
  // pipeline control: a stage loads when it is empty or its word moves on
  // --------------------------------------------------------------------------
  assign out_ld = !out_valid_r || !out_stall;
  assign en.ld4 = !v4_r || out_ld;
  assign en.ld3 = !v3_r || en.ld4;
  assign en.ld2 = !v2_r || en.ld3;
  assign en.ld1 = !v1_r || en.ld2;

  assign in_stall = !en.ld1;

  always_comb begin
    v1_nxt        = en.ld1 ? in_valid : v1_r;
    v2_nxt        = en.ld2 ? v1_r     : v2_r;
    v3_nxt        = en.ld3 ? v2_r     : v3_r;
    v4_nxt        = en.ld4 ? v3_r     : v4_r;
    out_valid_nxt = out_ld ? v4_r     : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  ssp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .voice   (voice),
    .hl_text (hl_text),
    .hl_len  (hl_len)
  );

  // rotate portrait into the landscape canvas; out-of-range columns go negative
  assign canvas_x = in_panel_row;
  assign canvas_y = $signed(11'(PANEL_WIDTH - 1) - {2'b00, in_panel_column});

  // --------------------------------------------------------------------------
  // shape layers and the four text lanes run side by side, aligned at stage 4
  // --------------------------------------------------------------------------
  ssp_shape u_shape (
    .clk    (clk),
    .en     (en),
    .voice  (voice),
    .x      (canvas_x),
    .y      (canvas_y),
    .colour (shape_colour)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ssp_text_lane #(
      .LANE (g)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .x       (canvas_x),
      .y       (canvas_y),
      .hl_text (hl_text),
      .hl_len  (hl_len),
      .hit     (hits[g])
    );
  end

  // text wins over shapes; title first, then headline, mic line, agent label
  always_comb begin
    out_colour_nxt = shape_colour;
    if (hits[LANE_TITLE]) begin
      out_colour_nxt = COL_WHITE;
    end else if (hits[LANE_HEAD]) begin
      out_colour_nxt = voice ? COL_ORANGE : COL_MINT;
    end else if (hits[LANE_MIC]) begin
      out_colour_nxt = COL_MINT;
    end else if (hits[LANE_AGENT]) begin
      out_colour_nxt = COL_CYAN;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) out_colour_r <= out_colour_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_colour = out_colour_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // input only stalls when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r))
    else $error("input stalled with an empty pipeline stage");

  // a new result only comes from stage 4
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v4_r))
    else $error("output became valid without a word in stage 4");

  // an accepted word lands in stage 1
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted word lost at stage 1");

  // headline length is either a fixed word or the full store
  a_hl_len: assert property (@(posedge clk) disable iff (!rst_n)
    (hl_len == FIXED_HL_LEN) || (hl_len == FULL_HL_LEN))
    else $error("headline length out of range");

endmodule
